// ===== design/skl_pkg.sv =====
package skl_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam int YEAR_W  = 16;
  localparam int FLOW_W  = 32;
  localparam int COUNT_W = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch a request and register the key compares
    logic apply;      // commit insert or remove, load a single result
    logic read_step;  // emit the head entry and rotate the row
  } skl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic is_read;
    logic count_zero;
    logic read_last;
  } skl_stat_t;

endpackage

// ===== design/skl_ctrl.sv =====
module skl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output skl_pkg::skl_cmd_t cmd,
  input  skl_pkg::skl_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_read && !stat.count_zero) begin
          state_nxt = S_READ;
        end else if (stat.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          cmd.read_step = 1'b1;
          if (stat.read_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/skl_datapath.sv =====
module skl_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_mode,
  input  logic [skl_pkg::YEAR_W-1:0]        in_key_year,
  input  logic [skl_pkg::FLOW_W-1:0]        in_flow_value,
  input  skl_pkg::skl_cmd_t                 cmd,
  output skl_pkg::skl_stat_t                stat,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [skl_pkg::YEAR_W-1:0]        out_year,
  output logic [skl_pkg::FLOW_W-1:0]        out_flow,
  output logic                              out_last,
  output logic [skl_pkg::COUNT_W-1:0]       out_entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Row of cells, kept sorted by year below count_r.
  logic [skl_pkg::YEAR_W-1:0] year_r   [CAPACITY];
  logic [skl_pkg::FLOW_W-1:0] flow_r   [CAPACITY];
  logic [skl_pkg::YEAR_W-1:0] year_nxt [CAPACITY];
  logic [skl_pkg::FLOW_W-1:0] flow_nxt [CAPACITY];

  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic [CW-1:0]              rd_cnt_r;
  logic [1:0]                 mode_r;
  logic [skl_pkg::YEAR_W-1:0] key_r;
  logic [skl_pkg::FLOW_W-1:0] flow_in_r;
  logic [CAPACITY-1:0]        ge_r;
  logic [CAPACITY-1:0]        ge_nxt;
  logic [CAPACITY-1:0]        hit_first;
  logic                       found_r;

  logic                       full;
  logic                       do_ins;
  logic                       do_rem;
  logic                       do_rot;
  logic                       read_last;
  logic [1:0]                 single_status;
  logic [CW+skl_pkg::COUNT_W-1:0] cnt_nxt_ext;
  logic [CW+skl_pkg::COUNT_W-1:0] cnt_cur_ext;

  assign full      = (count_r == CW'(CAPACITY));
  assign read_last = (rd_cnt_r == count_r - CW'(1));
  assign do_ins    = cmd.apply && (mode_r == skl_pkg::MODE_INSERT) && !full;
  assign do_rem    = cmd.apply && (mode_r == skl_pkg::MODE_REMOVE) && found_r;
  assign do_rot    = cmd.read_step;

  // Every cell compares against the incoming key in parallel. Because the row is
  // sorted, the first cell at or above the key is where an insert lands and where
  // the first match of a remove must sit.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
    localparam logic [CW-1:0] IDX = CW'(g);
    assign ge_nxt[g] = (IDX < count_r) && (year_r[g] >= in_key_year);
    if (g == 0) begin : g_head
      assign hit_first[g] = (IDX < count_r) && (year_r[g] == in_key_year);
    end else begin : g_body
      assign hit_first[g] = (IDX < count_r) && (year_r[g] == in_key_year) &&
                            (year_r[g-1] != in_key_year);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CW-1:0] IDX  = CW'(g);
    localparam logic [CW-1:0] IDX1 = CW'(g + 1);
    logic [skl_pkg::YEAR_W-1:0] prev_year;
    logic [skl_pkg::FLOW_W-1:0] prev_flow;
    logic [skl_pkg::YEAR_W-1:0] next_year;
    logic [skl_pkg::FLOW_W-1:0] next_flow;
    logic                       prev_ge;

    if (g == 0) begin : g_first
      assign prev_year = year_r[0];
      assign prev_flow = flow_r[0];
      assign prev_ge   = 1'b0;
    end else begin : g_mid
      assign prev_year = year_r[g-1];
      assign prev_flow = flow_r[g-1];
      assign prev_ge   = ge_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign next_year = year_r[g];
      assign next_flow = flow_r[g];
    end else begin : g_notlast
      assign next_year = year_r[g+1];
      assign next_flow = flow_r[g+1];
    end

    always_comb begin
      year_nxt[g] = year_r[g];
      flow_nxt[g] = flow_r[g];
      if (do_ins) begin
        if (prev_ge) begin
          year_nxt[g] = prev_year;
          flow_nxt[g] = prev_flow;
        end else if (ge_r[g] || (IDX == count_r)) begin
          year_nxt[g] = key_r;
          flow_nxt[g] = flow_in_r;
        end
      end else if (do_rem) begin
        if (ge_r[g]) begin
          year_nxt[g] = next_year;
          flow_nxt[g] = next_flow;
        end
      end else if (do_rot) begin
        // The occupied part of the row turns by one, so after a full read-all
        // every entry is back in place.
        if (IDX1 < count_r) begin
          year_nxt[g] = next_year;
          flow_nxt[g] = next_flow;
        end else if (IDX1 == count_r) begin
          year_nxt[g] = year_r[0];
          flow_nxt[g] = flow_r[0];
        end
      end
    end

    always_ff @(posedge clk) begin
      year_r[g] <= year_nxt[g];
      flow_r[g] <= flow_nxt[g];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    case (mode_r)
      skl_pkg::MODE_INSERT: single_status = full ? skl_pkg::ST_FULL : skl_pkg::ST_OK;
      skl_pkg::MODE_REMOVE: single_status = found_r ? skl_pkg::ST_OK : skl_pkg::ST_NOTFOUND;
      skl_pkg::MODE_READ:   single_status = skl_pkg::ST_EMPTY;
      default:              single_status = skl_pkg::ST_OK;
    endcase
  end

  assign cnt_nxt_ext = {{skl_pkg::COUNT_W{1'b0}}, count_nxt};
  assign cnt_cur_ext = {{skl_pkg::COUNT_W{1'b0}}, count_r};

  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.is_read    = (mode_r == skl_pkg::MODE_READ);
  assign stat.count_zero = (count_r == '0);
  assign stat.read_last  = read_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.apply || cmd.read_step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= in_mode;
      key_r     <= in_key_year;
      flow_in_r <= in_flow_value;
      ge_r      <= ge_nxt;
      found_r   <= |hit_first;
      rd_cnt_r  <= '0;
    end else if (cmd.read_step) begin
      rd_cnt_r <= rd_cnt_r + CW'(1);
    end
    if (cmd.apply) begin
      out_status      <= single_status;
      out_year        <= '0;
      out_flow        <= '0;
      out_last        <= 1'b1;
      out_entry_count <= cnt_nxt_ext[skl_pkg::COUNT_W-1:0];
    end else if (cmd.read_step) begin
      out_status      <= skl_pkg::ST_OK;
      out_year        <= year_r[0];
      out_flow        <= flow_r[0];
      out_last        <= read_last;
      out_entry_count <= cnt_cur_ext[skl_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ===== design/sorted_key_list_engine.sv =====
// Sorted key list engine: holds up to CAPACITY (year, flow) entries in ascending
// year order. Requests arrive on the in_ channel (in_valid, in_stall) carrying a
// mode, a key year and a flow payload; results leave on the out_ channel
// (out_valid, out_stall). An insert places the entry ahead of any equal years,
// a remove deletes the first matching year, and a read-all emits every entry in
// order with out_last on the final one (an empty store gives one empty result).
// Insert, remove and the unused mode give one result each, with out_last set.
// An insert or remove has its key compares registered when the request is taken;
// its change is then committed and its result loaded into the output register
// once that register is free, and no new request is taken before then. A read-all
// passes through the same compare step and then emits its entries from the read
// state. The compare step registers the key compare of every cell in parallel;
// the apply step shifts the cell row, and a read-all turns the row by one entry
// per cycle, unless out_stall holds the output, while the head entry is emitted.
// One request is in flight at a time: in_stall stays high until its last result
// has been loaded into the output register. When out_stall is high with out_valid
// set, the output register holds its result and the engine waits, losing nothing.
// A synchronous active-low reset empties the store and clears both channels.
module sorted_key_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic [skl_pkg::YEAR_W-1:0]  in_key_year,
  input  logic [skl_pkg::FLOW_W-1:0]  in_flow_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [skl_pkg::YEAR_W-1:0]  out_year,
  output logic [skl_pkg::FLOW_W-1:0]  out_flow,
  output logic                        out_last,
  output logic [skl_pkg::COUNT_W-1:0] out_entry_count
);

  skl_pkg::skl_cmd_t  cmd;
  skl_pkg::skl_stat_t stat;

  skl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  skl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_key_year     (in_key_year),
    .in_flow_value   (in_flow_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_year        (out_year),
    .out_flow        (out_flow),
    .out_last        (out_last),
    .out_entry_count (out_entry_count)
  );

  // A request taken always leaves the input side busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again right after a request");

  // Only a final result (out_last set) can carry a status other than ok.
  a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == skl_pkg::ST_OK))
    else $error("intermediate read result with non-ok status");

  // An empty-store result is a single final result with a zero count.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == skl_pkg::ST_EMPTY)) |->
      (out_last && (out_entry_count == '0)))
    else $error("empty-store result malformed");

  // The controller never issues two commands at once.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.apply, cmd.read_step}))
    else $error("conflicting datapath commands");

endmodule
